### rtl/tksd_pkg.sv
// Shared types and constants of the terminal key sequence decoder.
// Used by the controller, the datapath and the top level; depends on nothing.
package tksd_pkg;

  // Depth of the sequence buffer and of the replay queue.
  localparam int SEQ_DEPTH   = 7;
  // Most commands that one input key may cause.
  localparam int MAX_RESULTS = 7;

  localparam int CODE_W = 21;
  localparam int KEY_W  = CODE_W + 1;
  localparam int NUM_W  = 17;
  localparam int CNT_W  = $clog2(SEQ_DEPTH + 1);
  localparam int IDX_W  = $clog2(SEQ_DEPTH);
  localparam int RES_W  = $clog2(MAX_RESULTS + 1);

  // Keys as held inside: bit 21 is the control flag, bits 20..0 the code.
  localparam logic [KEY_W-1:0] CSI_KEY    = 22'h00_009B;
  localparam logic [KEY_W-1:0] ESC_KEY    = 22'h20_005B;
  localparam logic [KEY_W-1:0] META_RESET = 22'h20_005B;
  localparam logic [KEY_W-1:0] CTLX_RESET = 22'h20_0058;
  localparam logic [KEY_W-1:0] KEY_O      = 22'h00_004F;
  localparam logic [KEY_W-1:0] KEY_LBR    = 22'h00_005B;
  localparam logic [KEY_W-1:0] KEY_TILDE  = 22'h00_007E;
  localparam logic [KEY_W-1:0] KEY_SEMI   = 22'h00_003B;
  localparam logic [KEY_W-1:0] KEY_P      = 22'h00_0050;
  localparam logic [KEY_W-1:0] KEY_S      = 22'h00_0053;
  localparam logic [KEY_W-1:0] KEY_0      = 22'h00_0030;
  localparam logic [KEY_W-1:0] KEY_9      = 22'h00_0039;
  localparam logic [KEY_W-1:0] KEY_UA     = 22'h00_0041;
  localparam logic [KEY_W-1:0] KEY_UZ     = 22'h00_005A;
  localparam logic [KEY_W-1:0] KEY_LA     = 22'h00_0061;
  localparam logic [KEY_W-1:0] KEY_LZ     = 22'h00_007A;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_META_KEY = 1'b0,
    REG_CTLX_KEY = 1'b1
  } reg_idx_t;

  // Prefix that waits for the next key.
  typedef enum logic [1:0] {
    PRE_NONE = 2'b00,
    PRE_META = 2'b01,
    PRE_CTLX = 2'b10
  } prefix_t;

  // Where the parser stands inside a sequence.
  typedef enum logic [3:0] {
    PH_IDLE = 4'b0001,
    PH_ESC  = 4'b0010,
    PH_SS3  = 4'b0100,
    PH_CSI  = 4'b1000
  } phase_t;

  // One command as delivered on the output channel.
  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic              ctl;
    logic              meta;
    logic              ctlx;
    logic              special;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic feed;
    logic merge;
    logic plain;
    logic flush;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic rc_zero;
    logic nres_full;
    logic feed_fail;
    logic merge_last;
    logic hold_valid;
    logic out_free;
  } dp_stat_t;

endpackage

### rtl/terminal_key_sequence_decoder_unit.sv
// Top level of the terminal key sequence decoder.
// Joins tksd_ctrl and tksd_dp; uses tksd_pkg.
//
// Decodes keys one beat at a time into editor commands: ESC O P..S and
// ESC [ or CSI "n~", "n;m~" or letter sequences become special-key commands,
// meta and control-X prefixes are applied, and a sequence that does not match
// is replayed key by key. A key is taken only while no earlier key is in
// work. The key is taken into the replay queue and each queued key is decoded
// in turn; a failed sequence is merged back into that queue key by key and
// its first key is then taken again as a plain key; once the queue is empty
// or the command limit is reached, the last command is handed over. The
// sequential decoder handles one key per cycle while no held command waits
// on a stalled output and no failed sequence is being merged back. The last
// command of an input key is marked by last_of_run, and a key that only
// opens a sequence or sets a prefix yields no command at all.
module terminal_key_sequence_decoder_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [tksd_pkg::CODE_W-1:0]  key_code,
  input  logic                         key_ctl,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [tksd_pkg::KEY_W-1:0]   cfg_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [tksd_pkg::CODE_W-1:0]  cmd_code,
  output logic                         cmd_ctl,
  output logic                         cmd_meta,
  output logic                         cmd_ctlx,
  output logic                         cmd_special,
  output logic                         last_of_run
);
  import tksd_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;
  result_t  out_res;

  // Sequencing.
  tksd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  // Storage and decoding.
  tksd_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .key_code    (key_code),
    .key_ctl     (key_ctl),
    .cfg_we      (cfg_we),
    .cfg_index   (reg_idx_t'(cfg_index)),
    .cfg_data    (cfg_data),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_res     (out_res),
    .last_of_run (last_of_run)
  );

  // Output fields.
  assign cmd_code    = out_res.code;
  assign cmd_ctl     = out_res.ctl;
  assign cmd_meta    = out_res.meta;
  assign cmd_ctlx    = out_res.ctlx;
  assign cmd_special = out_res.special;

`ifndef ASSERT_OFF
  // Only one key is in work at a time.
  assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("key taken while an earlier key was in work");

  // Only the last command of a run may still wait when a new key is taken.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !last_of_run) |-> in_stall)
    else $error("block idle while a command that is not last waits");
`endif

endmodule

### rtl/tksd_ctrl.sv
// Controller of the terminal key sequence decoder: the state machine that
// sequences load, decode, replay merge and output flush. Uses tksd_pkg.
module tksd_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  tksd_pkg::dp_stat_t stat,
  output tksd_pkg::dp_cmd_t  cmd
);
  import tksd_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_RUN   = 5'b00010,
    S_MERGE = 5'b00100,
    S_PLAIN = 5'b01000,
    S_FLUSH = 5'b10000
  } state_t;

  state_t state, state_next;
  logic   slot_ok;

  // A new command may be made when none is held or the held one can move to the output.
  assign slot_ok  = !stat.hold_valid || stat.out_free;
  assign in_stall = (state != S_IDLE);

  // Next state and commands.
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_RUN;
        end
      end
      S_RUN: begin
        if (!stat.nres_full && !stat.rc_zero) begin
          if (slot_ok) begin
            cmd.feed = 1'b1;
            if (stat.feed_fail) begin
              state_next = S_MERGE;
            end
          end
        end else begin
          state_next = S_FLUSH;
        end
      end
      S_MERGE: begin
        cmd.merge = 1'b1;
        if (stat.merge_last) begin
          state_next = S_PLAIN;
        end
      end
      S_PLAIN: begin
        if (slot_ok) begin
          cmd.plain  = 1'b1;
          state_next = S_RUN;
        end
      end
      S_FLUSH: begin
        if (!stat.hold_valid) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          cmd.flush  = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### rtl/tksd_dp.sv
// Datapath of the terminal key sequence decoder: replay queue, sequence
// buffer, parser registers, prefix keys and the output stage. Uses tksd_pkg.
module tksd_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  tksd_pkg::dp_cmd_t             cmd,
  output tksd_pkg::dp_stat_t            stat,
  input  logic [tksd_pkg::CODE_W-1:0]   key_code,
  input  logic                          key_ctl,
  input  logic                          cfg_we,
  input  tksd_pkg::reg_idx_t            cfg_index,
  input  logic [tksd_pkg::KEY_W-1:0]    cfg_data,
  input  logic                          out_stall,
  output logic                          out_valid,
  output tksd_pkg::result_t             out_res,
  output logic                          last_of_run
);
  import tksd_pkg::*;

  typedef enum logic [1:0] {
    NUM_KEEP  = 2'b00,
    NUM_CLEAR = 2'b01,
    NUM_SEMI  = 2'b10,
    NUM_DIGIT = 2'b11
  } num_op_t;

  localparam logic [CODE_W-1:0] CASE_OFFSET = 21'd32;
  localparam logic [CODE_W-1:0] DIGIT_BASE  = 21'h30;
  localparam logic [CODE_W-1:0] LETTER_BASE = 21'h57;

  logic [KEY_W-1:0]  replay_keys [SEQ_DEPTH];
  logic [CNT_W-1:0]  replay_count;
  logic [KEY_W-1:0]  seq_keys [SEQ_DEPTH];
  logic [CNT_W-1:0]  seq_count;
  phase_t            parse_phase;
  prefix_t           pending_prefix;
  logic [NUM_W-1:0]  first_number;
  logic [NUM_W-1:0]  second_number;
  logic [IDX_W-1:0]  merge_idx;
  logic [RES_W-1:0]  nres;
  logic [KEY_W-1:0]  meta_key;
  logic [KEY_W-1:0]  ctlx_key;
  result_t           hold;
  logic              hold_valid;

  logic [KEY_W-1:0]  head;
  logic              out_free;

  // Plain key handling.
  logic              pl_emit;
  prefix_t           pl_prefix;
  result_t           pl_res;

  // Sequence decoding.
  logic              fd_emit;
  logic              fd_fail;
  result_t           fd_res;
  prefix_t           fd_prefix;
  phase_t            fd_phase;
  logic [CNT_W-1:0]  fd_seq_count;
  num_op_t           fd_num_op;
  logic [CNT_W-1:0]  seq_inc;
  logic              is_digit;
  logic              is_letter;
  logic              is_term;

  // Function-key termination.
  logic [NUM_W-1:0]  mod_less;
  logic [NUM_W-1:0]  csi_value;
  logic              csi_meta;
  logic              csi_ctlx;
  logic              csi_ctl;
  logic [CODE_W-1:0] csi_code;

  logic              produced;
  result_t           new_res;
  logic              load_out;
  logic [NUM_W-1:0]  second_times_ten;

  assign head     = replay_keys[0];
  assign out_free = !out_valid || !out_stall;
  assign seq_inc  = seq_count + CNT_W'(1);

  assign is_digit  = (head >= KEY_0) && (head <= KEY_9);
  assign is_letter = ((head >= KEY_UA) && (head <= KEY_UZ)) ||
                     ((head >= KEY_LA) && (head <= KEY_LZ));
  assign is_term   = (head == KEY_TILDE) || is_letter;

  // As itself: meta key and unprefixed control-X absorbed; others sent.
  always_comb begin
    pl_res.code    = head[CODE_W-1:0];
    pl_res.ctl     = head[KEY_W-1];
    pl_res.meta    = (pending_prefix == PRE_META);
    pl_res.ctlx    = (pending_prefix == PRE_CTLX);
    pl_res.special = 1'b0;
    if ((pending_prefix != PRE_NONE) && !head[KEY_W-1] &&
        (head >= KEY_LA) && (head <= KEY_LZ)) begin
      pl_res.code = head[CODE_W-1:0] - CASE_OFFSET;
    end
    pl_emit   = 1'b0;
    pl_prefix = pending_prefix;
    if (head == meta_key) begin
      pl_prefix = PRE_META;
    end else if ((head == ctlx_key) && (pending_prefix == PRE_NONE)) begin
      pl_prefix = PRE_CTLX;
    end else begin
      pl_emit   = 1'b1;
      pl_prefix = PRE_NONE;
    end
  end

  // Number and modifier of a CSI sequence and the code it stands for.
  always_comb begin
    mod_less  = second_number - NUM_W'(1);
    csi_meta  = (pending_prefix == PRE_META);
    csi_ctlx  = (pending_prefix == PRE_CTLX);
    csi_ctl   = 1'b0;
    csi_value = second_number;
    if (first_number != '0) begin
      if (mod_less[1]) begin
        csi_meta = 1'b1;
        csi_ctlx = 1'b0;
      end
      if (mod_less[2]) begin
        csi_ctl = 1'b1;
      end
      csi_value = first_number;
    end
    if (head == KEY_TILDE) begin
      if (csi_value <= NUM_W'(9)) begin
        csi_code = CODE_W'(csi_value) + DIGIT_BASE;
      end else begin
        csi_code = CODE_W'(csi_value) + LETTER_BASE;
      end
    end else begin
      csi_code = head[CODE_W-1:0];
    end
  end

  // One key through the sequence parser.
  always_comb begin
    fd_emit      = 1'b0;
    fd_fail      = 1'b0;
    fd_res       = '0;
    fd_prefix    = pending_prefix;
    fd_phase     = parse_phase;
    fd_seq_count = seq_inc;
    fd_num_op    = NUM_KEEP;
    unique case (parse_phase)
      PH_IDLE: begin
        if (head == CSI_KEY) begin
          fd_phase  = PH_CSI;
          fd_num_op = NUM_CLEAR;
        end else if (head == ESC_KEY) begin
          fd_phase = PH_ESC;
        end else begin
          fd_seq_count = '0;
          fd_emit      = pl_emit;
          fd_res       = pl_res;
          fd_prefix    = pl_prefix;
        end
      end
      PH_ESC: begin
        if (head == KEY_O) begin
          fd_phase = PH_SS3;
        end else if (head == KEY_LBR) begin
          fd_phase  = PH_CSI;
          fd_num_op = NUM_CLEAR;
        end else begin
          fd_fail = 1'b1;
        end
      end
      PH_SS3: begin
        if ((head >= KEY_P) && (head <= KEY_S)) begin
          fd_emit        = 1'b1;
          fd_res.code    = head[CODE_W-1:0];
          fd_res.ctl     = 1'b0;
          fd_res.meta    = (pending_prefix == PRE_META);
          fd_res.ctlx    = (pending_prefix == PRE_CTLX);
          fd_res.special = 1'b1;
          fd_prefix      = PRE_NONE;
          fd_phase       = PH_IDLE;
          fd_seq_count   = '0;
        end else begin
          fd_fail = 1'b1;
        end
      end
      PH_CSI: begin
        if (is_term) begin
          if ((head == KEY_TILDE) && (csi_value == '0)) begin
            fd_fail = 1'b1;
          end else begin
            fd_emit        = 1'b1;
            fd_res.code    = csi_code;
            fd_res.ctl     = csi_ctl;
            fd_res.meta    = csi_meta;
            fd_res.ctlx    = csi_ctlx;
            fd_res.special = 1'b1;
            fd_prefix      = PRE_NONE;
            fd_phase       = PH_IDLE;
            fd_seq_count   = '0;
          end
        end else if ((head == KEY_SEMI) || is_digit) begin
          fd_num_op = (head == KEY_SEMI) ? NUM_SEMI : NUM_DIGIT;
          if (seq_inc >= CNT_W'(SEQ_DEPTH)) begin
            fd_fail = 1'b1;
          end
        end else begin
          fd_fail = 1'b1;
        end
      end
      default: begin
        fd_phase     = PH_IDLE;
        fd_seq_count = '0;
      end
    endcase
    // A failed sequence goes back to the replay queue.
    if (fd_fail) begin
      fd_phase     = PH_IDLE;
      fd_seq_count = '0;
    end
  end

  assign second_times_ten = (second_number << 3) + (second_number << 1);

  assign produced = (cmd.feed && fd_emit) || (cmd.plain && pl_emit);
  assign new_res  = cmd.feed ? fd_res : pl_res;
  assign load_out = (produced && hold_valid) || cmd.flush;

  assign stat.rc_zero    = (replay_count == '0);
  assign stat.nres_full  = (nres == RES_W'(MAX_RESULTS));
  assign stat.feed_fail  = fd_fail;
  assign stat.merge_last = (merge_idx == '0);
  assign stat.hold_valid = hold_valid;
  assign stat.out_free   = out_free;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      replay_count   <= '0;
      seq_count      <= '0;
      parse_phase    <= PH_IDLE;
      pending_prefix <= PRE_NONE;
      first_number   <= '0;
      second_number  <= '0;
      nres           <= '0;
      meta_key       <= META_RESET;
      ctlx_key       <= CTLX_RESET;
      hold_valid     <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      // Configuration writes.
      if (cfg_we) begin
        unique case (cfg_index)
          REG_META_KEY: meta_key <= cfg_data;
          REG_CTLX_KEY: ctlx_key <= cfg_data;
        endcase
      end

      // Replay queue fill count.
      if (cmd.load) begin
        if (replay_count < CNT_W'(SEQ_DEPTH)) begin
          replay_count <= replay_count + CNT_W'(1);
        end
      end else if (cmd.feed || cmd.plain) begin
        replay_count <= replay_count - CNT_W'(1);
      end else if (cmd.merge) begin
        if (replay_count != CNT_W'(SEQ_DEPTH)) begin
          replay_count <= replay_count + CNT_W'(1);
        end
      end

      // Parser state.
      if (cmd.feed) begin
        seq_count      <= fd_seq_count;
        parse_phase    <= fd_phase;
        pending_prefix <= fd_prefix;
        unique case (fd_num_op)
          NUM_KEEP: begin
          end
          NUM_CLEAR: begin
            first_number  <= '0;
            second_number <= '0;
          end
          NUM_SEMI: begin
            first_number  <= second_number;
            second_number <= '0;
          end
          NUM_DIGIT: begin
            second_number <= second_times_ten + NUM_W'(head[3:0]);
          end
        endcase
      end else if (cmd.plain) begin
        pending_prefix <= pl_prefix;
      end

      // Commands sent during the current run.
      if (cmd.load) begin
        nres <= '0;
      end else if (produced) begin
        nres <= nres + RES_W'(1);
      end

      // Held command and output register.
      if (produced) begin
        hold_valid <= 1'b1;
      end else if (cmd.flush) begin
        hold_valid <= 1'b0;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Key stores and payload registers.
  always_ff @(posedge clk) begin
    if (cmd.load && (replay_count < CNT_W'(SEQ_DEPTH))) begin
      replay_keys[replay_count[IDX_W-1:0]] <= {key_ctl, key_code};
    end else if (cmd.feed || cmd.plain) begin
      for (int i = 0; i < SEQ_DEPTH - 1; i++) begin
        replay_keys[i] <= replay_keys[i+1];
      end
    end else if (cmd.merge) begin
      replay_keys[0] <= seq_keys[merge_idx];
      for (int i = 1; i < SEQ_DEPTH; i++) begin
        replay_keys[i] <= replay_keys[i-1];
      end
    end

    if (cmd.feed && (seq_count < CNT_W'(SEQ_DEPTH))) begin
      seq_keys[seq_count[IDX_W-1:0]] <= head;
    end

    // Replay merge runs from the newest stored key down to the first.
    if (cmd.feed && fd_fail) begin
      merge_idx <= seq_count[IDX_W-1:0];
    end else if (cmd.merge) begin
      merge_idx <= merge_idx - IDX_W'(1);
    end

    if (produced) begin
      hold <= new_res;
    end
    if (produced && hold_valid) begin
      out_res     <= hold;
      last_of_run <= 1'b0;
    end else if (cmd.flush) begin
      out_res     <= hold;
      last_of_run <= 1'b1;
    end
  end

endmodule

### tb/sv/tksd_command_checker.sv
// Checker for the terminal key sequence decoder: watches both channels and
// the configuration port, predicts the commands and compares every output beat.
// Depends on tksd_pkg only.
module tksd_command_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [tksd_pkg::CODE_W-1:0] key_code,
  input  logic                        key_ctl,
  input  logic                        cfg_we,
  input  logic                        cfg_index,
  input  logic [tksd_pkg::KEY_W-1:0]  cfg_data,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [tksd_pkg::CODE_W-1:0] cmd_code,
  input  logic                        cmd_ctl,
  input  logic                        cmd_meta,
  input  logic                        cmd_ctlx,
  input  logic                        cmd_special,
  input  logic                        last_of_run,
  output int                          fail_count,
  output int                          backlog
);
  timeunit 1ns;
  timeprecision 1ps;

  import tksd_pkg::*;

  typedef struct packed {
    result_t cmd;
    logic    last;
  } cmd_beat_t;

  // Shadow copy of the prefix key registers.
  logic [KEY_W-1:0] meta_reg;
  logic [KEY_W-1:0] ctlx_reg;

  // Shadow copy of the decoder state.
  logic [KEY_W-1:0] replay_q [SEQ_DEPTH];
  int               replay_n;
  logic [KEY_W-1:0] seq_buf [SEQ_DEPTH];
  int               seq_n;
  phase_t           phase;
  prefix_t          prefix;
  logic [NUM_W-1:0] num_a;
  logic [NUM_W-1:0] num_b;

  // Commands caused by the key now being decoded, and all commands still owed.
  cmd_beat_t        step_cmds [MAX_RESULTS];
  int               step_n;
  cmd_beat_t        expected_cmds [$];

  function automatic void push_cmd(input logic [CODE_W-1:0] code, input logic ctl,
                                   input logic meta, input logic ctlx,
                                   input logic special);
    cmd_beat_t b;
    if (step_n >= MAX_RESULTS) return;
    b.cmd.code    = code;
    b.cmd.ctl     = ctl;
    b.cmd.meta    = meta;
    b.cmd.ctlx    = ctlx;
    b.cmd.special = special;
    b.last        = 1'b0;
    step_cmds[step_n] = b;
    step_n++;
  endfunction

  function automatic void end_seq();
    prefix = PRE_NONE;
    phase  = PH_IDLE;
    seq_n  = 0;
  endfunction

  function automatic logic [KEY_W-1:0] pop_key();
    logic [KEY_W-1:0] k;
    k = replay_q[0];
    for (int i = 0; i < replay_n - 1; i++) replay_q[i] = replay_q[i + 1];
    replay_n--;
    return k;
  endfunction

  function automatic void store_key(input logic [KEY_W-1:0] k);
    if (seq_n < SEQ_DEPTH) begin
      seq_buf[seq_n] = k;
      seq_n++;
    end
  endfunction

  // A plain key: a lower-case letter after a prefix is sent in upper case.
  function automatic void emit_plain(input logic [KEY_W-1:0] k);
    logic [CODE_W-1:0] code;
    logic              ctl;
    code = k[CODE_W-1:0];
    ctl  = k[KEY_W-1];
    if (prefix != PRE_NONE && !ctl && code >= KEY_LA[CODE_W-1:0] &&
        code <= KEY_LZ[CODE_W-1:0])
      code = code - (KEY_LA[CODE_W-1:0] - KEY_UA[CODE_W-1:0]);
    push_cmd(code, ctl, prefix == PRE_META, prefix == PRE_CTLX, 1'b0);
    end_seq();
  endfunction

  // The meta test comes first, so equal prefix keys act as meta.
  function automatic void plain_key(input logic [KEY_W-1:0] k);
    if (k == meta_reg) begin
      prefix = PRE_META;
    end else if (k == ctlx_reg) begin
      if (prefix != PRE_NONE) emit_plain(k);
      else prefix = PRE_CTLX;
    end else begin
      emit_plain(k);
    end
  endfunction

  // A failed sequence goes back to the head of the replay queue; its first key
  // is then taken only as a prefix or a plain key.
  function automatic void replay_failed();
    int n;
    n = seq_n;
    if (replay_n + n > SEQ_DEPTH) replay_n = SEQ_DEPTH - n;
    for (int i = replay_n - 1; i >= 0; i--) replay_q[i + n] = replay_q[i];
    for (int i = 0; i < n; i++) replay_q[i] = seq_buf[i];
    replay_n += n;
    seq_n = 0;
    phase = PH_IDLE;
    if (replay_n > 0) plain_key(pop_key());
  endfunction

  function automatic void open_csi();
    phase = PH_CSI;
    num_a = '0;
    num_b = '0;
  endfunction

  // Final key of a CSI sequence; the modifier decides meta and control.
  function automatic void close_csi(input logic [KEY_W-1:0] k);
    logic              m;
    logic              x;
    logic              c;
    logic [NUM_W-1:0]  v;
    logic [NUM_W-1:0]  d;
    logic [CODE_W-1:0] code;
    m    = (prefix == PRE_META);
    x    = (prefix == PRE_CTLX);
    c    = 1'b0;
    v    = num_b;
    code = k[CODE_W-1:0];
    if (num_a != '0) begin
      d = num_b - 1'b1;
      if (d[1]) begin
        m = 1'b1;
        x = 1'b0;
      end
      if (d[2]) c = 1'b1;
      v = num_a;
    end
    if (k == KEY_TILDE) begin
      if (v == '0) begin
        replay_failed();
        return;
      end
      if (v <= 9)
        code = {{(CODE_W-NUM_W){1'b0}}, v} + KEY_0[CODE_W-1:0];
      else
        code = {{(CODE_W-NUM_W){1'b0}}, v} + KEY_LA[CODE_W-1:0] - CODE_W'(10);
    end
    push_cmd(code, c, m, x, 1'b1);
    end_seq();
  endfunction

  function automatic void feed_key(input logic [KEY_W-1:0] k);
    case (phase)
      PH_IDLE: begin
        seq_n = 0;
        store_key(k);
        if (k == CSI_KEY) begin
          open_csi();
        end else if (k == ESC_KEY) begin
          phase = PH_ESC;
        end else begin
          seq_n = 0;
          plain_key(k);
        end
      end
      PH_ESC: begin
        store_key(k);
        if (k == KEY_O) phase = PH_SS3;
        else if (k == KEY_LBR) open_csi();
        else replay_failed();
      end
      PH_SS3: begin
        store_key(k);
        if (k >= KEY_P && k <= KEY_S) begin
          push_cmd(k[CODE_W-1:0], 1'b0, prefix == PRE_META, prefix == PRE_CTLX, 1'b1);
          end_seq();
        end else begin
          replay_failed();
        end
      end
      default: begin
        store_key(k);
        if (k == KEY_TILDE || (k >= KEY_UA && k <= KEY_UZ) ||
            (k >= KEY_LA && k <= KEY_LZ)) begin
          close_csi(k);
        end else if (k == KEY_SEMI || (k >= KEY_0 && k <= KEY_9)) begin
          if (k == KEY_SEMI) begin
            num_a = num_b;
            num_b = '0;
          end else begin
            num_b = NUM_W'(num_b * 10 + (k - KEY_0));
          end
          if (seq_n >= SEQ_DEPTH) replay_failed();
        end else begin
          replay_failed();
        end
      end
    endcase
  endfunction

  // Decode one accepted key and queue the commands it causes.
  function automatic void decode_key(input logic [KEY_W-1:0] k);
    step_n = 0;
    if (replay_n < SEQ_DEPTH) begin
      replay_q[replay_n] = k;
      replay_n++;
    end
    while (step_n < MAX_RESULTS && replay_n > 0) feed_key(pop_key());
    if (step_n > 0) step_cmds[step_n - 1].last = 1'b1;
    for (int i = 0; i < step_n; i++) expected_cmds.push_back(step_cmds[i]);
  endfunction

  task automatic report_mismatch(input string what, input logic [CODE_W-1:0] got,
                                 input logic [CODE_W-1:0] want);
    fail_count++;
    $display("mismatch at %0t: %s got %0h, wanted %0h", $time, what, got, want);
  endtask

  // Compare one output beat with the oldest command still owed.
  task automatic check_beat();
    cmd_beat_t got;
    cmd_beat_t want;
    got.cmd.code    = cmd_code;
    got.cmd.ctl     = cmd_ctl;
    got.cmd.meta    = cmd_meta;
    got.cmd.ctlx    = cmd_ctlx;
    got.cmd.special = cmd_special;
    got.last        = last_of_run;
    if (expected_cmds.size() == 0) begin
      report_mismatch("command beat with none expected", got.cmd.code, '0);
      return;
    end
    want = expected_cmds.pop_front();
    if (got.cmd.code !== want.cmd.code)
      report_mismatch("cmd_code", got.cmd.code, want.cmd.code);
    if (got.cmd.ctl !== want.cmd.ctl)
      report_mismatch("cmd_ctl", CODE_W'(got.cmd.ctl), CODE_W'(want.cmd.ctl));
    if (got.cmd.meta !== want.cmd.meta)
      report_mismatch("cmd_meta", CODE_W'(got.cmd.meta), CODE_W'(want.cmd.meta));
    if (got.cmd.ctlx !== want.cmd.ctlx)
      report_mismatch("cmd_ctlx", CODE_W'(got.cmd.ctlx), CODE_W'(want.cmd.ctlx));
    if (got.cmd.special !== want.cmd.special)
      report_mismatch("cmd_special", CODE_W'(got.cmd.special),
                      CODE_W'(want.cmd.special));
    if (got.last !== want.last)
      report_mismatch("last_of_run", CODE_W'(got.last), CODE_W'(want.last));
  endtask

  // Output beats are checked before a new key is decoded at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      meta_reg   = META_RESET;
      ctlx_reg   = CTLX_RESET;
      replay_n   = 0;
      seq_n      = 0;
      phase      = PH_IDLE;
      prefix     = PRE_NONE;
      num_a      = '0;
      num_b      = '0;
      fail_count = 0;
      expected_cmds.delete();
    end else begin
      if (out_valid && !out_stall) check_beat();
      if (cfg_we) begin
        if (cfg_index == REG_META_KEY) meta_reg = cfg_data;
        else ctlx_reg = cfg_data;
      end
      if (in_valid && !in_stall) decode_key({key_ctl, key_code});
    end
    backlog = expected_cmds.size();
  end

endmodule

### tb/sv/terminal_key_sequence_decoder_unit_test.sv
// Testbench top of the terminal key sequence decoder: clock, reset, key and
// configuration stimulus, output stalls, watchdog and verdict.
// Depends on tksd_pkg, terminal_key_sequence_decoder_unit and tksd_command_checker.
module terminal_key_sequence_decoder_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  import tksd_pkg::*;

  // Cycles without any beat before the run is given up.
  localparam int QUIET_LIMIT  = 1000;
  // Cycles allowed for a key that causes no command to leave the block.
  localparam int DRAIN_CYCLES = 60;
  localparam logic [KEY_W-1:0] KEY_BANG = 22'h00_0021;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [CODE_W-1:0] key_code  = '0;
  logic              key_ctl   = 1'b0;
  logic              cfg_we    = 1'b0;
  logic              cfg_index = REG_META_KEY;
  logic [KEY_W-1:0]  cfg_data  = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [CODE_W-1:0] cmd_code;
  logic              cmd_ctl;
  logic              cmd_meta;
  logic              cmd_ctlx;
  logic              cmd_special;
  logic              last_of_run;

  int                fail_count;
  int                backlog;
  int                quiet       = 0;
  int                stall_left  = 0;
  bit                idling      = 1'b1;
  logic [KEY_W-1:0]  cur_meta    = META_RESET;
  logic [KEY_W-1:0]  cur_ctlx    = CTLX_RESET;
  logic [KEY_W-1:0]  key_plan [$];

  terminal_key_sequence_decoder_unit dut (
    .clk, .rst, .in_valid, .in_stall, .key_code, .key_ctl,
    .cfg_we, .cfg_index, .cfg_data,
    .out_valid, .out_stall, .cmd_code, .cmd_ctl, .cmd_meta, .cmd_ctlx,
    .cmd_special, .last_of_run
  );

  tksd_command_checker u_checker (
    .clk, .rst, .in_valid, .in_stall, .key_code, .key_ctl,
    .cfg_we, .cfg_index, .cfg_data,
    .out_valid, .out_stall, .cmd_code, .cmd_ctl, .cmd_meta, .cmd_ctlx,
    .cmd_special, .last_of_run,
    .fail_count, .backlog
  );

  always #5 clk = ~clk;

  // Receiver stalls come in bursts of random length, started only while idling is set.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if (idling && $urandom_range(0, 4) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet >= QUIET_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Offer one key and hold it until the block takes the beat.
  task automatic send_key(input logic [KEY_W-1:0] k);
    int gap;
    if (idling && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 3);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    key_ctl  <= k[KEY_W-1];
    key_code <= k[CODE_W-1:0];
    @(posedge clk);
    while (!(in_valid && !in_stall)) @(posedge clk);
  endtask

  task automatic run_plan();
    while (key_plan.size() > 0) send_key(key_plan.pop_front());
  endtask

  // Stop sending until every owed command has arrived and the block is quiet.
  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (backlog != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_prefix_keys(input logic [KEY_W-1:0] meta, input logic [KEY_W-1:0] ctlx);
    cfg_we    <= 1'b1;
    cfg_index <= REG_META_KEY;
    cfg_data  <= meta;
    @(posedge clk);
    cfg_index <= REG_CTLX_KEY;
    cfg_data  <= ctlx;
    @(posedge clk);
    cfg_we   <= 1'b0;
    cur_meta = meta;
    cur_ctlx = ctlx;
  endtask

  function automatic logic [KEY_W-1:0] digit_key();
    return KEY_0 + KEY_W'($urandom_range(0, 9));
  endfunction

  function automatic logic [KEY_W-1:0] letter_key();
    int r;
    r = $urandom_range(0, 25);
    return ($urandom_range(0, 1) != 0) ? KEY_UA + KEY_W'(r) : KEY_LA + KEY_W'(r);
  endfunction

  // A key near the decoder's decisions, sometimes with the control flag,
  // or a fully random one so that every bit of both fields moves.
  function automatic logic [KEY_W-1:0] odd_key();
    logic [KEY_W-1:0] k;
    case ($urandom_range(0, 10))
      0:       k = CSI_KEY;
      1:       k = KEY_O;
      2:       k = KEY_LBR;
      3:       k = KEY_TILDE;
      4:       k = KEY_SEMI;
      5:       k = digit_key();
      6:       k = letter_key();
      7:       k = KEY_P + KEY_W'($urandom_range(0, 3));
      8:       return ESC_KEY;
      9:       return ($urandom_range(0, 1) != 0) ? cur_meta : cur_ctlx;
      default: return KEY_W'($urandom);
    endcase
    if ($urandom_range(0, 3) == 0) k[KEY_W-1] = 1'b1;
    return k;
  endfunction

  // Plan one burst: mostly well-formed sequences with random content,
  // the rest prefixes, noise and broken sequences.
  task automatic plan_burst();
    int kind;
    int n;
    kind = $urandom_range(0, 9);
    if (kind <= 5 && $urandom_range(0, 3) == 0)
      key_plan.push_back(($urandom_range(0, 1) != 0) ? cur_meta : cur_ctlx);
    case (kind)
      0, 1: begin
        key_plan.push_back(ESC_KEY);
        key_plan.push_back(KEY_O);
        key_plan.push_back(($urandom_range(0, 4) == 0) ? odd_key()
                           : KEY_P + KEY_W'($urandom_range(0, 3)));
      end
      2, 3, 4, 5: begin
        if ($urandom_range(0, 1) != 0) begin
          key_plan.push_back(CSI_KEY);
        end else begin
          key_plan.push_back(ESC_KEY);
          key_plan.push_back(KEY_LBR);
        end
        n = $urandom_range(0, 2);
        repeat (n) key_plan.push_back(digit_key());
        if ($urandom_range(0, 1) != 0) begin
          key_plan.push_back(KEY_SEMI);
          n = $urandom_range(0, 1);
          repeat (n) key_plan.push_back(digit_key());
        end
        if ($urandom_range(0, 7) == 0) key_plan.push_back(odd_key());
        key_plan.push_back(($urandom_range(0, 1) != 0) ? KEY_TILDE : letter_key());
      end
      6: begin
        key_plan.push_back(($urandom_range(0, 1) != 0) ? cur_meta : cur_ctlx);
        key_plan.push_back(($urandom_range(0, 2) != 0) ? letter_key() : odd_key());
      end
      7, 8: begin
        key_plan.push_back(odd_key());
      end
      default: begin
        key_plan.push_back(($urandom_range(0, 1) != 0) ? CSI_KEY : ESC_KEY);
        n = $urandom_range(1, 7);
        repeat (n)
          key_plan.push_back(($urandom_range(0, 1) != 0) ? digit_key() : odd_key());
      end
    endcase
  endtask

  task automatic random_phase(input int count);
    int sent;
    sent = 0;
    while (sent < count) begin
      plan_burst();
      sent += key_plan.size();
      run_plan();
    end
  endtask

  // Directed keys: field extremes, both sequence forms and the corner cases.
  task automatic directed_keys();
    // Plain letter, largest code with and without the control flag.
    key_plan.push_back(KEY_LA);
    key_plan.push_back({1'b1, {CODE_W{1'b1}}});
    key_plan.push_back({1'b0, {CODE_W{1'b1}}});
    // ESC O S.
    key_plan.push_back(ESC_KEY);
    key_plan.push_back(KEY_O);
    key_plan.push_back(KEY_S);
    // CSI 1 5 ~, a number above nine.
    key_plan.push_back(CSI_KEY);
    key_plan.push_back(KEY_0 + KEY_W'(1));
    key_plan.push_back(KEY_0 + KEY_W'(5));
    key_plan.push_back(KEY_TILDE);
    // ESC [ 3 ; ~ with the modifier left out.
    key_plan.push_back(ESC_KEY);
    key_plan.push_back(KEY_LBR);
    key_plan.push_back(KEY_0 + KEY_W'(3));
    key_plan.push_back(KEY_SEMI);
    key_plan.push_back(KEY_TILDE);
    // CSI ; 2 a with an empty leading number.
    key_plan.push_back(CSI_KEY);
    key_plan.push_back(KEY_SEMI);
    key_plan.push_back(KEY_0 + KEY_W'(2));
    key_plan.push_back(KEY_LA);
    // Tilde with no number fails and is replayed.
    key_plan.push_back(CSI_KEY);
    key_plan.push_back(KEY_TILDE);
    // A control key never continues a sequence.
    key_plan.push_back(ESC_KEY);
    key_plan.push_back({1'b1, KEY_O[CODE_W-1:0]});
    // Control-X twice, then meta and a lower-case letter.
    key_plan.push_back(CTLX_RESET);
    key_plan.push_back(CTLX_RESET);
    key_plan.push_back(META_RESET);
    key_plan.push_back(KEY_LA + KEY_W'(1));
    // A failed sequence of full depth replays into the most commands per key.
    key_plan.push_back(CSI_KEY);
    for (int d = 1; d <= 5; d++) key_plan.push_back(KEY_0 + KEY_W'(d));
    key_plan.push_back(KEY_BANG);
    run_plan();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    directed_keys();
    random_phase(50);

    // Extreme prefix keys, one way round and then the other.
    drain();
    set_prefix_keys('0, '1);
    random_phase(45);
    drain();
    set_prefix_keys('1, '0);
    random_phase(40);

    // Both prefix registers on the same key.
    drain();
    cur_meta = {1'($urandom_range(0, 1)), 21'($urandom_range(0, 127))};
    set_prefix_keys(cur_meta, cur_meta);
    random_phase(40);

    // Random prefix keys, and the sender waits for every command mid-phase.
    drain();
    set_prefix_keys({1'($urandom_range(0, 1)), 21'($urandom_range(0, 127))},
                    {1'($urandom_range(0, 1)), 21'($urandom_range(0, 127))});
    random_phase(25);
    drain();
    random_phase(25);

    // Back to the reset keys, with no idling on either side.
    drain();
    set_prefix_keys(META_RESET, CTLX_RESET);
    idling = 1'b0;
    random_phase(45);

    drain();
    @(negedge clk);
    if (fail_count == 0 && backlog == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
